[sv/bis_pkg.sv]
// Package for the bilinear image scaler: field widths, register indexes,
// reset values and default frame limits. No dependencies.
`timescale 1ns / 1ps

package bis_pkg;

  // Default frame store limits
  localparam int BIS_MAX_WIDTH  = 512;
  localparam int BIS_MAX_HEIGHT = 512;

  // Field widths
  localparam int COORD_W    = 13;
  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 10;
  localparam int STEP_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 2'd2;

  // Register reset values
  localparam logic [SIZE_W-1:0] SRC_WIDTH_RST  = 10'd512;
  localparam logic [SIZE_W-1:0] SRC_HEIGHT_RST = 10'd512;
  localparam logic [STEP_W-1:0] STEP_RST       = 24'd65536;

  // Request codes
  typedef enum logic {
    REQ_STORE  = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_e;

endpackage

[sv/bis_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on bis_pkg for the default width and depth.
`timescale 1ns / 1ps

module bis_ram
  import bis_pkg::*;
#(
  parameter int WIDTH = PIX_W,
  parameter int DEPTH = BIS_MAX_WIDTH * BIS_MAX_HEIGHT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/bilinear_image_scaler.sv]
// Bilinear image scaler top level: config registers, sample sequencer and
// the frame store. Depends on bis_pkg and bis_ram.
`timescale 1ns / 1ps

// Usage
//   Command channel: a transaction is taken at a clock edge with start high
//   and busy low. req_type_i selects a store (write pixel_value_i at
//   column_i/row_i, dropped when outside the configured frame) or a sample
//   (interpolate output pixel column_i/row_i).
//   Config channel: cfg_valid_i/cfg_ready_o carrying cfg_index_i and
//   cfg_data_i; ready is always high. Write only while busy is low.
//   Result: sample_valid_o is high for exactly one cycle with sample_value_o.
//   Nothing can stall it; the receiver must take it in that cycle.
// Timing
//   A store leaves busy low, so a new transaction may follow at the next edge.
//   A sample holds busy through multiply, clamp, four frame reads, last
//   accumulate and output, so no new transaction is taken until it is done.
//   The result strobe and value are registered from the output step. The
//   single read port of the frame store, read once per neighbor, sets how
//   long a sample holds busy.
// Reset
//   Registers return to width 512, height 512, step 1.0. The frame store is
//   not cleared; pixels must be stored before they are sampled.
module bilinear_image_scaler
  import bis_pkg::*;
#(
  parameter int MAX_WIDTH  = BIS_MAX_WIDTH,
  parameter int MAX_HEIGHT = BIS_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  req_type_i,
  input  logic [COORD_W-1:0]    column_i,
  input  logic [COORD_W-1:0]    row_i,
  input  logic [PIX_W-1:0]      pixel_value_i,
  // configuration channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // result
  output logic                  sample_valid_o,
  output logic [PIX_W-1:0]      sample_value_o
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = COORD_W + STEP_W;  // coordinate times step
  localparam int IXW   = PW - 16;           // integer source index
  localparam int WW    = 17;                // weight, up to 65536
  localparam int ACC_W = 24;                // sum of weights is 65536

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CLAMP,
    ST_READ,
    ST_LAST,
    ST_DONE
  } state_e;

  function automatic logic [AW-1:0] pix_addr(input logic [XW-1:0] x,
                                             input logic [YW-1:0] y);
    return AW'(32'(y) * MAX_WIDTH + 32'(x));
  endfunction

  // Configuration registers
  logic [SIZE_W-1:0] src_width_q, src_height_q;
  logic [STEP_W-1:0] step_q;

  // Sequencer registers
  state_e           state_q;
  logic [COORD_W-1:0] col_q, row_q;
  logic [IXW-1:0]   ix_q, iy_q;
  logic [7:0]       fxx_q, fyy_q;
  logic [XW-1:0]    sx_q, sxx_q;
  logic [YW-1:0]    sy_q, syy_q;
  logic [WW-1:0]    wgt_q [4];
  logic [1:0]       cnt_q, sel_q;
  logic             rd_vld_q;
  logic [ACC_W-1:0] acc_q;
  logic             sample_valid_q;
  logic [PIX_W-1:0] sample_value_q;

  // Effective frame size minus one
  logic [XW-1:0] wm1;
  logic [YW-1:0] hm1;

  always_comb begin
    if (src_width_q == '0) begin
      wm1 = '0;
    end else if (32'(src_width_q) > MAX_WIDTH) begin
      wm1 = XW'(MAX_WIDTH - 1);
    end else begin
      wm1 = XW'(src_width_q - SIZE_W'(1));
    end
    if (src_height_q == '0) begin
      hm1 = '0;
    end else if (32'(src_height_q) > MAX_HEIGHT) begin
      hm1 = YW'(MAX_HEIGHT - 1);
    end else begin
      hm1 = YW'(src_height_q - SIZE_W'(1));
    end
  end

  // Command handshake and store path
  logic accept, store_we;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign store_we = accept && (req_type_i == REQ_STORE) &&
                    (column_i <= COORD_W'(wm1)) && (row_i <= COORD_W'(hm1));

  // Source position: coordinate times step, 16 fraction bits
  logic [PW-1:0] prod_x, prod_y;

  assign prod_x = PW'(col_q) * PW'(step_q);
  assign prod_y = PW'(row_q) * PW'(step_q);

  // Neighbor clamp at the frame edge
  logic [XW-1:0] sx_d, sxx_d;
  logic [YW-1:0] sy_d, syy_d;

  assign sx_d  = (ix_q > IXW'(wm1)) ? wm1 : ix_q[XW-1:0];
  assign sy_d  = (iy_q > IXW'(hm1)) ? hm1 : iy_q[YW-1:0];
  assign sxx_d = (sx_d == wm1) ? wm1 : sx_d + XW'(1);
  assign syy_d = (sy_d == hm1) ? hm1 : sy_d + YW'(1);

  // Blend weights
  logic [8:0] fx, fy;

  assign fx = 9'd256 - {1'b0, fxx_q};
  assign fy = 9'd256 - {1'b0, fyy_q};

  // Neighbor read: bit 0 of the count picks the right column, bit 1 the
  // lower row
  logic [XW-1:0]    rd_x;
  logic [YW-1:0]    rd_y;
  logic [PIX_W-1:0] rd_data;

  assign rd_x = cnt_q[0] ? sxx_q : sx_q;
  assign rd_y = cnt_q[1] ? syy_q : sy_q;

  // Multiply-accumulate of the returning neighbor
  logic [ACC_W-1:0] mac;

  assign mac = acc_q + ACC_W'(wgt_q[sel_q]) * ACC_W'(rd_data);

  // Frame store
  bis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (pix_addr(column_i[XW-1:0], row_i[YW-1:0])),
    .wdata_i (pixel_value_i),
    .re_i    (state_q == ST_READ),
    .raddr_i (pix_addr(rd_x, rd_y)),
    .rdata_o (rd_data)
  );

  // Config registers, sequencer state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q    <= SRC_WIDTH_RST;
      src_height_q   <= SRC_HEIGHT_RST;
      step_q         <= STEP_RST;
      state_q        <= ST_IDLE;
      col_q          <= '0;
      row_q          <= '0;
      ix_q           <= '0;
      iy_q           <= '0;
      fxx_q          <= '0;
      fyy_q          <= '0;
      sx_q           <= '0;
      sxx_q          <= '0;
      sy_q           <= '0;
      syy_q          <= '0;
      for (int i = 0; i < 4; i++) begin
        wgt_q[i] <= '0;
      end
      cnt_q          <= '0;
      sel_q          <= '0;
      rd_vld_q       <= 1'b0;
      acc_q          <= '0;
      sample_valid_q <= 1'b0;
      sample_value_q <= '0;
    end else begin
      // config transaction
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SRC_WIDTH:  src_width_q  <= cfg_data_i[SIZE_W-1:0];
          CFG_SRC_HEIGHT: src_height_q <= cfg_data_i[SIZE_W-1:0];
          CFG_STEP:       step_q       <= cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end

      rd_vld_q       <= (state_q == ST_READ);
      sel_q          <= cnt_q;
      sample_valid_q <= (state_q == ST_DONE);
      if (rd_vld_q) begin
        acc_q <= mac;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept && (req_type_i == REQ_SAMPLE)) begin
            col_q   <= column_i;
            row_q   <= row_i;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          ix_q    <= prod_x[PW-1:16];
          iy_q    <= prod_y[PW-1:16];
          fxx_q   <= prod_x[15:8];
          fyy_q   <= prod_y[15:8];
          state_q <= ST_CLAMP;
        end
        ST_CLAMP: begin
          sx_q     <= sx_d;
          sxx_q    <= sxx_d;
          sy_q     <= sy_d;
          syy_q    <= syy_d;
          wgt_q[0] <= WW'(fx) * WW'(fy);
          wgt_q[1] <= WW'(fxx_q) * WW'(fy);
          wgt_q[2] <= WW'(fx) * WW'(fyy_q);
          wgt_q[3] <= WW'(fxx_q) * WW'(fyy_q);
          acc_q    <= '0;
          cnt_q    <= '0;
          state_q  <= ST_READ;
        end
        ST_READ: begin
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            state_q <= ST_LAST;
          end
        end
        ST_LAST: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          // weights sum to 65536, so the top byte never exceeds 255
          sample_value_q <= acc_q[ACC_W-1:16];
          state_q        <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign sample_valid_o = sample_valid_q;
  assign sample_value_o = sample_value_q;

endmodule

[verif/bilinear_image_scaler_test.sv]
// Self-checking testbench for bilinear_image_scaler: directed edge cases, then
// random store/sample traffic over a series of frame and step settings.
// Depends on bis_pkg and the bilinear_image_scaler RTL.
`timescale 1ns / 1ps

module bilinear_image_scaler_test;
  import bis_pkg::*;

  localparam int FRAME_DEPTH  = BIS_MAX_WIDTH * BIS_MAX_HEIGHT;
  localparam int QUIET_LIMIT  = 2000;  // cycles without any transaction
  localparam int DRAIN_CYCLES = 12;    // cycles to wait once no result is pending
  localparam int PHASE_ITEMS  = 135;
  localparam int NUM_PHASES   = 9;
  localparam int MAX_COORD    = (1 << COORD_W) - 1;

  // Index with no register behind it; writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  // Scoreboard: mirrors the frame store and registers, predicts each sample
  class resample_checker;
    bit   [PIX_W-1:0]  frame [FRAME_DEPTH];
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [STEP_W-1:0] step_reg;
    logic [PIX_W-1:0]  pending_pixels [$];
    int stores_kept;
    int stores_dropped;
    int samples_checked;
    int mismatches;

    function new();
      width_reg  = SRC_WIDTH_RST;
      height_reg = SRC_HEIGHT_RST;
      step_reg   = STEP_RST;
    endfunction

    // zero acts as one, oversize acts as the limit
    function int unsigned clamp_size(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function int unsigned cols();
      return clamp_size(width_reg, BIS_MAX_WIDTH);
    endfunction

    function int unsigned rows();
      return clamp_size(height_reg, BIS_MAX_HEIGHT);
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SRC_WIDTH:  width_reg  = data[SIZE_W-1:0];
        CFG_SRC_HEIGHT: height_reg = data[SIZE_W-1:0];
        CFG_STEP:       step_reg   = data[STEP_W-1:0];
        default: ;  // unknown index, no effect
      endcase
    endfunction

    // Source neighbors (clamped to the frame) and 8-bit fractions of a sample
    function void locate(input logic [COORD_W-1:0] col, row,
                         output int unsigned x0, x1, y0, y1, fx, fy);
      logic [36:0] bx;
      logic [36:0] by;
      int unsigned w;
      int unsigned h;
      w  = cols();
      h  = rows();
      bx = ({24'd0, col} * {13'd0, step_reg}) >> 8;
      by = ({24'd0, row} * {13'd0, step_reg}) >> 8;
      x0 = (bx[36:8] > w - 1) ? w - 1 : int'(bx[36:8]);
      y0 = (by[36:8] > h - 1) ? h - 1 : int'(by[36:8]);
      x1 = (x0 + 1 > w - 1) ? w - 1 : x0 + 1;
      y1 = (y0 + 1 > h - 1) ? h - 1 : y0 + 1;
      fx = bx[7:0];
      fy = by[7:0];
    endfunction

    function void note_request(req_e req, logic [COORD_W-1:0] col, row,
                               logic [PIX_W-1:0] pix);
      int unsigned x0, x1, y0, y1, fx, fy, acc;
      if (req == REQ_STORE) begin
        if (col < cols() && row < rows()) begin
          frame[row * BIS_MAX_WIDTH + col] = pix;
          stores_kept++;
        end else begin
          stores_dropped++;
        end
      end else begin
        locate(col, row, x0, x1, y0, y1, fx, fy);
        acc = (256 - fx) * (256 - fy) * frame[y0 * BIS_MAX_WIDTH + x0]
            + fx * (256 - fy) * frame[y0 * BIS_MAX_WIDTH + x1]
            + (256 - fx) * fy * frame[y1 * BIS_MAX_WIDTH + x0]
            + fx * fy * frame[y1 * BIS_MAX_WIDTH + x1];
        acc = acc >> 16;
        if (acc > 255) acc = 255;
        pending_pixels.push_back(acc[PIX_W-1:0]);
      end
    endfunction

    function void check_sample(logic [PIX_W-1:0] actual);
      logic [PIX_W-1:0] want;
      if (pending_pixels.size() == 0) begin
        $error("sample_value: expected none pending, actual %0d", actual);
        mismatches++;
        return;
      end
      want = pending_pixels.pop_front();
      samples_checked++;
      if (actual !== want) begin
        $error("sample_value: expected %0d, actual %0d", want, actual);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  req_type = REQ_STORE;
  logic [COORD_W-1:0]    column = '0;
  logic [COORD_W-1:0]    row = '0;
  logic [PIX_W-1:0]      pixel_value = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  sample_valid;
  logic [PIX_W-1:0]      sample_value;

  resample_checker sb = new();
  bit pix_written [FRAME_DEPTH];  // pixels the stimulus has already stored
  int idle_pct = 8;
  int quiet_cycles = 0;
  int items_sent = 0;             // command transactions accepted so far

  bilinear_image_scaler u_top (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type),
    .column_i       (column),
    .row_i          (row),
    .pixel_value_i  (pixel_value),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .sample_valid_o (sample_valid),
    .sample_value_o (sample_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: every transaction is seen at the rising edge; watchdog alongside
  always @(posedge clk) begin
    if (rst_ni) begin
      if (sample_valid) sb.check_sample(sample_value);
      if (start && !busy) sb.note_request(req_e'(req_type), column, row, pixel_value);
      if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
      if (sample_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
        $display("[bilinear_image_scaler] ERROR");
        $finish;
      end
    end
  end

  // One command transaction, with random idle cycles ahead of it
  task automatic send_cmd(req_e req, logic [COORD_W-1:0] col, logic [COORD_W-1:0] rw,
                          logic [PIX_W-1:0] pix);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    req_type    <= req;
    column      <= col;
    row         <= rw;
    pixel_value <= pix;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic put_pixel(int unsigned col, int unsigned rw, int unsigned pix);
    if (col < sb.cols() && rw < sb.rows()) pix_written[rw * BIS_MAX_WIDTH + col] = 1'b1;
    send_cmd(REQ_STORE, COORD_W'(col), COORD_W'(rw), PIX_W'(pix));
  endtask

  task automatic fill_if_empty(int unsigned x, int unsigned y);
    if (!pix_written[y * BIS_MAX_WIDTH + x]) put_pixel(x, y, $urandom_range(255));
  endtask

  // Store any neighbor not yet written, then sample
  task automatic sample_at(int unsigned col, int unsigned rw);
    int unsigned x0, x1, y0, y1, fx, fy;
    sb.locate(COORD_W'(col), COORD_W'(rw), x0, x1, y0, y1, fx, fy);
    fill_if_empty(x0, y0);
    fill_if_empty(x1, y0);
    fill_if_empty(x0, y1);
    fill_if_empty(x1, y1);
    send_cmd(REQ_SAMPLE, COORD_W'(col), COORD_W'(rw), PIX_W'($urandom_range(255)));
  endtask

  // Hold off new commands until every result is in and the block has settled
  task automatic quiesce();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned w, h, mc, mr, c, rw;
    int pw, ph, ps, phase_start, r;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // Directed: reset settings, corners, dropped stores, beyond-frame samples
    put_pixel(0, 0, 0);
    put_pixel(511, 511, 255);
    put_pixel(512, 5, 255);
    put_pixel(MAX_COORD, MAX_COORD, 255);
    put_pixel(3, MAX_COORD, 0);
    sample_at(0, 0);
    sample_at(511, 511);
    sample_at(MAX_COORD, MAX_COORD);
    sample_at(510, 3);
    // half-pixel step: real blending, and clamped neighbors keep the fraction
    quiesce();
    cfg_write(CFG_STEP, 24'h008000);
    sample_at(1, 1);
    sample_at(1023, 1023);
    sample_at(MAX_COORD, 0);
    // zero step maps everything to the origin
    quiesce();
    cfg_write(CFG_STEP, 24'h000000);
    sample_at(MAX_COORD, MAX_COORD);
    // zero sizes act as a 1x1 frame; unmapped index is dropped
    quiesce();
    cfg_write(CFG_SRC_WIDTH, 24'h000000);
    cfg_write(CFG_SRC_HEIGHT, 24'h000000);
    cfg_write(CFG_UNMAPPED, 24'hFFFFFF);
    put_pixel(1, 0, 99);
    put_pixel(0, 0, 200);
    sample_at(77, MAX_COORD);
    sample_at(0, 0);

    // Random phases, each with its own frame size and step
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       begin pw = 512;  ph = 512; ps = 65536;     end
        1:       begin pw = 16;   ph = 16;  ps = 32768;     end
        2:       begin pw = 1023; ph = 700; ps = 'hFFFFFF;  end
        3:       begin pw = 0;    ph = 0;   ps = 0;         end
        4:       begin pw = 1;    ph = 512; ps = 1;         end
        5:       begin pw = 37;   ph = 23;  ps = $urandom_range(1, 'h2FFFF); end
        6:       begin pw = 512;  ph = 1;   ps = $urandom_range(1, 'h2FFFF); end
        7:       begin pw = 300;  ph = 200; ps = $urandom_range(1, 'h2FFFF); end
        default: begin pw = 2;    ph = 512; ps = $urandom_range(1, 'h2FFFF); end
      endcase
      idle_pct = (p < 3) ? 8 : (p < 6) ? 50 : 0;
      quiesce();
      cfg_write(CFG_UNMAPPED, CFG_DATA_W'($urandom));
      cfg_write(CFG_SRC_WIDTH, {14'($urandom), 10'(pw)});
      cfg_write(CFG_SRC_HEIGHT, {14'($urandom), 10'(ph)});
      cfg_write(CFG_STEP, CFG_DATA_W'(ps));

      w = sb.cols();
      h = sb.rows();
      // output coordinate range that lands in or just past the frame
      if (ps == 0) begin
        mc = MAX_COORD;
        mr = MAX_COORD;
      end else begin
        mc = ((longint'(w) + 1) * 65536 / ps > MAX_COORD) ? MAX_COORD
           : int'((longint'(w) + 1) * 65536 / ps);
        mr = ((longint'(h) + 1) * 65536 / ps > MAX_COORD) ? MAX_COORD
           : int'((longint'(h) + 1) * 65536 / ps);
      end

      // every command counts, neighbor fills included
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 30) begin
          put_pixel($urandom_range(w - 1), $urandom_range(h - 1), $urandom_range(255));
        end else if (r < 40) begin
          // store outside the frame, dropped by the block
          c  = $urandom_range(MAX_COORD);
          rw = $urandom_range(MAX_COORD);
          if (c < w && rw < h) c = w + $urandom_range(MAX_COORD - w);
          put_pixel(c, rw, $urandom_range(255));
        end else if (r < 85) begin
          sample_at($urandom_range(mc), $urandom_range(mr));
        end else begin
          sample_at($urandom_range(MAX_COORD), $urandom_range(MAX_COORD));
        end
        if ($urandom_range(99) == 0) quiesce();
      end
    end

    quiesce();
    $display("Covered %0d kept stores, %0d dropped stores, %0d checked samples",
             sb.stores_kept, sb.stores_dropped, sb.samples_checked);
    $display("over directed edge cases and %0d size/step settings at idle rates 8, 50, 0",
             NUM_PHASES);
    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0) begin
      $display("[bilinear_image_scaler] OK");
    end else begin
      $display("[bilinear_image_scaler] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
sv/bis_pkg.sv
sv/bis_ram.sv
sv/bilinear_image_scaler.sv
verif/bilinear_image_scaler_test.sv
